### rtl/core/jss_pkg.sv
// jss_pkg: shared types, widths and codes for the jet split selector
// depends on nothing; imported by every module of the block

package jss_pkg;

  localparam int FRAC_W  = 17;
  localparam int PT_W    = 22;
  localparam int ANGLE_W = 16;
  localparam int KT_W    = 22;
  localparam int KAPPA_W = 24;
  localparam int INDEX_W = 6;
  localparam int SCORE_W = 49;
  localparam int MUL_W   = 22;
  localparam int PART_W  = MUL_W + ANGLE_W;

  localparam int MODE_W  = 3;
  localparam int POWER_W = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 22;

  localparam int MAX_SPLITS_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
  localparam int DYN_SHIFT = 14;

  localparam logic [CFG_ADDR_W-1:0] REG_SELECT_MODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_POWER  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KT_THRESHOLD = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DYN_KAPPA = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SOFT_PT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_Z         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_KT        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LATE_KT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_KAPPA     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MAX_ZD2   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_MIN_ZD2   = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]  select_mode;
    logic [POWER_W-1:0] angle_power;
    logic [KT_W-1:0]    kt_threshold;
  } jss_cfg_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               eligible;
    logic               want_min;
    logic               last;
    logic [FRAC_W-1:0]  frac;
    logic [ANGLE_W-1:0] angle;
    logic [KT_W-1:0]    kt;
    logic [PT_W-1:0]    pt;
  } jss_item_t;

endpackage

### rtl/core/jet_split_selector_core.sv
// jet_split_selector_core: per-jet declustering selector, top level
// the front takes a new beat only after pushing the last one's score;
//   modes 0, 6 and 7 first score it on the front's shared 22x22 multiplier
// reset: rst_n sync active low, clears queue and jet state, cfg to defaults
// depends on jss_pkg, jss_front, jss_queue, jss_back

module jet_split_selector_core
  import jss_pkg::*;
#(
  parameter int MAX_SPLITS  = MAX_SPLITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mom_frac, pair_pt, open_angle, rel_kt, soft_pt, kappa_val, zero fill
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // best_index, best_frac, best_angle, best_kt, best_pt, zero fill
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // found, overflow
  output logic [OUT_USER_W-1:0]  out_tuser
);

  jss_cfg_t  cfg_r;
  jss_item_t push_item, pop_item;
  logic      push_valid, push_ready, pop_valid, pop_ready;

  logic [INDEX_W-1:0] best_index;
  logic [FRAC_W-1:0]  best_frac;
  logic [ANGLE_W-1:0] best_angle;
  logic [KT_W-1:0]    best_kt;
  logic [PT_W-1:0]    best_pt;
  logic               found, overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.select_mode  <= MODE_DYN_KAPPA;
      cfg_r.angle_power  <= POWER_W'(1);
      cfg_r.kt_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SELECT_MODE:  cfg_r.select_mode  <= cfg_wdata[MODE_W-1:0];
        REG_ANGLE_POWER:  cfg_r.angle_power  <= cfg_wdata[POWER_W-1:0];
        REG_KT_THRESHOLD: cfg_r.kt_threshold <= cfg_wdata[KT_W-1:0];
        default: ;
      endcase
    end
  end

  jss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .mom_frac   (in_tdata[16:0]),
    .pair_pt    (in_tdata[38:17]),
    .open_angle (in_tdata[54:39]),
    .rel_kt     (in_tdata[76:55]),
    .soft_pt    (in_tdata[98:77]),
    .kappa_val  (in_tdata[122:99]),
    .last_split (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  jss_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  jss_back #(
    .MaxSplits (MAX_SPLITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_item     (pop_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .best_index (best_index),
    .best_frac  (best_frac),
    .best_angle (best_angle),
    .best_kt    (best_kt),
    .best_pt    (best_pt),
    .found      (found),
    .overflow   (overflow)
  );

  assign out_tdata = {5'd0, best_pt, best_kt, best_angle, best_frac, best_index};
  assign out_tuser = {overflow, found};

endmodule

### rtl/core/jss_front.sv
// jss_front: takes declusterings, scores them; modes 0, 6, 7 use a shared multiplier
// depends on jss_pkg

module jss_front
  import jss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  jss_cfg_t            cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FRAC_W-1:0]   mom_frac,
  input  logic [PT_W-1:0]     pair_pt,
  input  logic [ANGLE_W-1:0]  open_angle,
  input  logic [KT_W-1:0]     rel_kt,
  input  logic [PT_W-1:0]     soft_pt,
  input  logic [KAPPA_W-1:0]  kappa_val,
  input  logic                last_split,
  output logic                push_valid,
  input  logic                push_ready,
  output jss_item_t           push_item
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ZQ   = 3'd1;
  localparam logic [2:0] ST_PT   = 3'd2;
  localparam logic [2:0] ST_ZA   = 3'd3;
  localparam logic [2:0] ST_ALO  = 3'd4;
  localparam logic [2:0] ST_AHI  = 3'd5;
  localparam logic [2:0] ST_PUSH = 3'd6;

  localparam int SUM_W = PART_W + MUL_W;

  logic [2:0]         state_r, state_nxt;
  logic [FRAC_W-1:0]  frac_r;
  logic [PT_W-1:0]    pt_r;
  logic [ANGLE_W-1:0] ang_r;
  logic [KT_W-1:0]    kt_r;
  logic               last_r, elig_r, wmin_r, dyn_r;
  logic [POWER_W-1:0] pw_r, pw_nxt;
  logic [SCORE_W-1:0] acc_r, acc_nxt;
  logic [PART_W-1:0]  part_r;

  logic [FRAC_W-1:0]  zc;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [SUM_W-1:0]   sum;
  logic               accept;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_ready && in_valid;
  assign push_valid = (state_r == ST_PUSH);

  assign zc = (frac_r > FRAC_ONE) ? FRAC_ONE : frac_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_ZQ: begin
        mul_a = MUL_W'(zc);
        mul_b = MUL_W'(FRAC_ONE - zc);
      end
      ST_PT: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = pt_r;
      end
      ST_ZA: begin
        mul_a = MUL_W'(frac_r);
        mul_b = MUL_W'(ang_r);
      end
      ST_ALO: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = MUL_W'(ang_r);
      end
      ST_AHI: begin
        mul_a = acc_r[2*MUL_W-1:MUL_W];
        mul_b = MUL_W'(ang_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = SUM_W'(part_r) + (SUM_W'(prod[PART_W-1:0]) << MUL_W);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    pw_nxt    = pw_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pw_nxt = cfg.angle_power;
          case (cfg.select_mode)
            MODE_DYN_KAPPA: state_nxt = ST_ZQ;
            MODE_MAX_ZD2, MODE_MIN_ZD2: state_nxt = ST_ZA;
            default: state_nxt = ST_PUSH;
          endcase
          case (cfg.select_mode)
            MODE_SOFT_PT: acc_nxt = SCORE_W'(soft_pt);
            MODE_Z:       acc_nxt = SCORE_W'(mom_frac);
            MODE_KT:      acc_nxt = SCORE_W'(rel_kt);
            MODE_LATE_KT: acc_nxt = SCORE_W'(open_angle);
            MODE_KAPPA:   acc_nxt = SCORE_W'(kappa_val);
            default:      acc_nxt = '0;
          endcase
        end
      end
      ST_ZQ: begin
        acc_nxt   = SCORE_W'(prod[2*MUL_W-1:16]);
        state_nxt = ST_PT;
      end
      ST_PT: begin
        acc_nxt   = SCORE_W'(prod);
        state_nxt = (pw_r != '0) ? ST_ALO : ST_PUSH;
      end
      ST_ZA: begin
        acc_nxt   = SCORE_W'(prod);
        state_nxt = ST_ALO;
      end
      ST_ALO: begin
        state_nxt = ST_AHI;
      end
      ST_AHI: begin
        acc_nxt = dyn_r ? SCORE_W'(sum >> DYN_SHIFT) : SCORE_W'(sum);
        if (!dyn_r || pw_r == POWER_W'(1)) begin
          state_nxt = ST_PUSH;
        end else begin
          pw_nxt    = pw_r - POWER_W'(1);
          state_nxt = ST_ALO;
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    pw_r  <= pw_nxt;
    if (state_r == ST_ALO) begin
      part_r <= prod[PART_W-1:0];
    end
    if (accept) begin
      frac_r <= mom_frac;
      pt_r   <= pair_pt;
      ang_r  <= open_angle;
      kt_r   <= rel_kt;
      last_r <= last_split;
      dyn_r  <= (cfg.select_mode == MODE_DYN_KAPPA);
      elig_r <= (cfg.select_mode != MODE_LATE_KT) || (rel_kt > cfg.kt_threshold);
      wmin_r <= (cfg.select_mode == MODE_LATE_KT) || (cfg.select_mode == MODE_MIN_ZD2);
    end
  end

  always_comb begin
    push_item.score    = acc_r;
    push_item.eligible = elig_r;
    push_item.want_min = wmin_r;
    push_item.last     = last_r;
    push_item.frac     = frac_r;
    push_item.angle    = ang_r;
    push_item.kt       = kt_r;
    push_item.pt       = pt_r;
  end

endmodule

### rtl/core/jss_queue.sv
// jss_queue: short fifo of scored items between the front and the back
// depends on jss_pkg

module jss_queue
  import jss_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  jss_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output jss_item_t rd_item
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  jss_item_t        mem_r [Depth];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != CNT_W'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PTR_W'(Depth - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PTR_W'(Depth - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

endmodule

### rtl/core/jss_back.sv
// jss_back: keeps the running best per jet and emits the result on the last beat
// depends on jss_pkg

module jss_back
  import jss_pkg::*;
#(
  parameter int MaxSplits = MAX_SPLITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  jss_item_t             q_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    best_index,
  output logic [FRAC_W-1:0]     best_frac,
  output logic [ANGLE_W-1:0]    best_angle,
  output logic [KT_W-1:0]       best_kt,
  output logic [PT_W-1:0]       best_pt,
  output logic                  found,
  output logic                  overflow
);

  localparam int CNT_W = $clog2(MaxSplits + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [INDEX_W-1:0] pos_r, pos_nxt;
  logic               found_r, found_nxt;
  logic               ovf_r, ovf_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [ANGLE_W-1:0] ang_r, ang_nxt;
  logic [KT_W-1:0]    kt_r, kt_nxt;
  logic [PT_W-1:0]    pt_r, pt_nxt;
  logic               take, pop;

  logic               ov_r;
  logic [INDEX_W-1:0] o_index_r;
  logic [FRAC_W-1:0]  o_frac_r;
  logic [ANGLE_W-1:0] o_angle_r;
  logic [KT_W-1:0]    o_kt_r;
  logic [PT_W-1:0]    o_pt_r;
  logic               o_found_r, o_ovf_r;

  assign q_ready = !q_item.last || !ov_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    cnt_nxt   = cnt_r;
    score_nxt = score_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    frac_nxt  = frac_r;
    ang_nxt   = ang_r;
    kt_nxt    = kt_r;
    pt_nxt    = pt_r;
    take      = 1'b0;
    if (cnt_r >= CNT_W'(MaxSplits)) begin
      ovf_nxt = 1'b1;
    end else begin
      if (!q_item.eligible) begin
        take = 1'b0;
      end else if (!found_r) begin
        take = 1'b1;
      end else begin
        take = q_item.want_min ? (q_item.score < score_r) : (q_item.score > score_r);
      end
      if (take) begin
        score_nxt = q_item.score;
        pos_nxt   = INDEX_W'(cnt_r);
        found_nxt = 1'b1;
        frac_nxt  = q_item.frac;
        ang_nxt   = q_item.angle;
        kt_nxt    = q_item.kt;
        pt_nxt    = q_item.pt;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      score_r <= '0;
      pos_r   <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
      frac_r  <= '0;
      ang_r   <= '0;
      kt_r    <= '0;
      pt_r    <= '0;
    end else if (pop) begin
      if (q_item.last) begin
        cnt_r   <= '0;
        score_r <= '0;
        pos_r   <= '0;
        found_r <= 1'b0;
        ovf_r   <= 1'b0;
        frac_r  <= '0;
        ang_r   <= '0;
        kt_r    <= '0;
        pt_r    <= '0;
      end else begin
        cnt_r   <= cnt_nxt;
        score_r <= score_nxt;
        pos_r   <= pos_nxt;
        found_r <= found_nxt;
        ovf_r   <= ovf_nxt;
        frac_r  <= frac_nxt;
        ang_r   <= ang_nxt;
        kt_r    <= kt_nxt;
        pt_r    <= pt_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (pop && q_item.last) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      o_found_r <= found_nxt;
      o_ovf_r   <= ovf_nxt;
      o_index_r <= found_nxt ? pos_nxt : '0;
      o_frac_r  <= found_nxt ? frac_nxt : '0;
      o_angle_r <= found_nxt ? ang_nxt : '0;
      o_kt_r    <= found_nxt ? kt_nxt : '0;
      o_pt_r    <= found_nxt ? pt_nxt : '0;
    end
  end

  assign out_valid  = ov_r;
  assign found      = o_found_r;
  assign overflow   = o_ovf_r;
  assign best_index = o_index_r;
  assign best_frac  = o_frac_r;
  assign best_angle = o_angle_r;
  assign best_kt    = o_kt_r;
  assign best_pt    = o_pt_r;

endmodule

### dv/tb_jet_split_selector_core.sv
// tb_jet_split_selector_core: self-checking bench for the jet split selector core
// drives declustering beats and register writes, predicts each jet's pick in a scoreboard
// depends on jss_pkg and jet_split_selector_core
`timescale 1ns / 1ps

module tb_jet_split_selector_core;
  import jss_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 1280;
  localparam int SETTLE = 16;
  localparam int O_FRAC  = INDEX_W;
  localparam int O_ANGLE = O_FRAC + FRAC_W;
  localparam int O_KT    = O_ANGLE + ANGLE_W;
  localparam int O_PT    = O_KT + KT_W;

  typedef struct {
    logic [FRAC_W-1:0]  frac;
    logic [PT_W-1:0]    pt;
    logic [ANGLE_W-1:0] angle;
    logic [KT_W-1:0]    kt;
    logic [PT_W-1:0]    soft_pt;
    logic [KAPPA_W-1:0] kappa;
    logic               last;
  } split_t;

  typedef struct {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [FRAC_W-1:0]  frac;
    logic [ANGLE_W-1:0] angle;
    logic [KT_W-1:0]    kt;
    logic [PT_W-1:0]    pt;
    logic               ovf;
  } pick_t;

  class split_scoreboard;
    logic [MODE_W-1:0]  mode;
    logic [POWER_W-1:0] power;
    logic [KT_W-1:0]    kt_cut;
    logic [63:0]        best_score;
    int unsigned        split_count;
    pick_t              held;
    pick_t              picks_q[$];
    int                 errors;

    function new();
      mode = MODE_DYN_KAPPA;
      power = 1;
      kt_cut = 0;
      errors = 0;
      clear_jet();
    endfunction

    function void clear_jet();
      best_score = 0;
      split_count = 0;
      held = '{default: 0};
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
      case (addr)
        REG_SELECT_MODE:  mode = val[MODE_W-1:0];
        REG_ANGLE_POWER:  power = val[POWER_W-1:0];
        REG_KT_THRESHOLD: kt_cut = val[KT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] grooming_score(split_t s);
      logic [63:0] zc;
      logic [63:0] acc;
      zc = (s.frac > FRAC_ONE) ? 64'd65536 : 64'(s.frac);
      acc = ((zc * (64'd65536 - zc)) >> 16) * 64'(s.pt);
      for (int k = 0; k < int'(power); k++) acc = (acc * 64'(s.angle)) >> DYN_SHIFT;
      return acc;
    endfunction

    function void note_split(split_t s);
      logic [63:0] score;
      logic [63:0] zd2;
      bit eligible;
      bit want_min;
      bit take;
      if (split_count >= MAX_SPLITS_DEF) begin
        held.ovf = 1;
      end else begin
        eligible = 1;
        want_min = 0;
        zd2 = 64'(s.frac) * 64'(s.angle) * 64'(s.angle);
        case (mode)
          MODE_DYN_KAPPA: score = grooming_score(s);
          MODE_SOFT_PT:   score = 64'(s.soft_pt);
          MODE_Z:         score = 64'(s.frac);
          MODE_KT:        score = 64'(s.kt);
          MODE_LATE_KT: begin
            score = 64'(s.angle);
            want_min = 1;
            eligible = s.kt > kt_cut;
          end
          MODE_KAPPA:     score = 64'(s.kappa);
          MODE_MAX_ZD2:   score = zd2;
          default: begin
            score = zd2;
            want_min = 1;
          end
        endcase
        if (!eligible) take = 0;
        else if (!held.found) take = 1;
        else take = want_min ? (score < best_score) : (score > best_score);
        if (take) begin
          best_score = score;
          held.found = 1;
          held.index = split_count[INDEX_W-1:0];
          held.frac = s.frac;
          held.angle = s.angle;
          held.kt = s.kt;
          held.pt = s.pt;
        end
        split_count++;
      end
      if (s.last) begin
        picks_q.push_back(held);
        clear_jet();
      end
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_pick(pick_t got);
      pick_t want;
      if (picks_q.size() == 0) begin
        report("result beat with no jet pending");
        return;
      end
      want = picks_q.pop_front();
      cmp("found", got.found, want.found);
      cmp("best_index", got.index, want.index);
      cmp("best_frac", got.frac, want.frac);
      cmp("best_angle", got.angle, want.angle);
      cmp("best_kt", got.kt, want.kt);
      cmp("best_pt", got.pt, want.pt);
      cmp("overflow", got.ovf, want.ovf);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // mom_frac, pair_pt, open_angle, rel_kt, soft_pt, kappa_val, zero fill
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  // best_index, best_frac, best_angle, best_kt, best_pt, zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  // found, overflow
  logic [OUT_USER_W-1:0] out_tuser;

  split_scoreboard sb;
  int     idle_pct = 0;
  bit     calm = 0;
  int     stall_left = 0;
  int     rand_sent = 0;
  split_t prev_split;
  bit     have_prev = 0;

  jet_split_selector_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("jet_split_selector_core regression: fail");
    $finish;
  end

  // sink side back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 0;
      stall_left <= stall_left - 1;
    end else if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_tready <= 0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    pick_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.index = out_tdata[0 +: INDEX_W];
      got.frac = out_tdata[O_FRAC +: FRAC_W];
      got.angle = out_tdata[O_ANGLE +: ANGLE_W];
      got.kt = out_tdata[O_KT +: KT_W];
      got.pt = out_tdata[O_PT +: PT_W];
      got.found = out_tuser[0];
      got.ovf = out_tuser[1];
      sb.check_pick(got);
    end
  end

  task write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    sb.set_reg(addr, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task send_split(split_t s);
    int gap;
    if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= IN_DATA_W'({s.kappa, s.soft_pt, s.kt, s.angle, s.pt, s.frac});
    in_tlast <= s.last;
    do @(posedge clk); while (!in_tready);
    sb.note_split(s);
    @(negedge clk);
  endtask

  task drain();
    in_tvalid <= 0;
    while (sb.picks_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic split_t mk(int unsigned frac, int unsigned pt, int unsigned ang,
                                int unsigned kt, int unsigned soft_val, int unsigned kap,
                                bit last);
    split_t s;
    s.frac = FRAC_W'(frac);
    s.pt = PT_W'(pt);
    s.angle = ANGLE_W'(ang);
    s.kt = KT_W'(kt);
    s.soft_pt = PT_W'(soft_val);
    s.kappa = KAPPA_W'(kap);
    s.last = last;
    return s;
  endfunction

  function automatic int unsigned field_value(int w);
    int unsigned mask;
    mask = (32'd1 << w) - 1;
    case ($urandom_range(7))
      0: return 0;
      1: return mask;
      2: return $urandom_range(15);
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic split_t rand_split(bit last);
    split_t s;
    if (have_prev && $urandom_range(7) == 0) begin
      s = prev_split;
    end else begin
      s.frac = ($urandom_range(7) == 0) ? FRAC_ONE : FRAC_W'(field_value(FRAC_W));
      s.pt = PT_W'(field_value(PT_W));
      s.angle = ANGLE_W'(field_value(ANGLE_W));
      s.kt = KT_W'(field_value(KT_W));
      s.soft_pt = PT_W'(field_value(PT_W));
      s.kappa = KAPPA_W'(field_value(KAPPA_W));
    end
    s.last = last;
    return s;
  endfunction

  initial begin
    int phase;
    int phase_items;
    int jet_len;
    logic [MODE_W-1:0] mode;
    logic [KT_W-1:0] cut;
    split_t s;
    rst_n = 0;
    cfg_we = 0;
    cfg_addr = 0;
    cfg_wdata = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    out_tready = 0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // reset settings: grooming score with alpha 1, zero score taken first, z saturation
    send_split(mk(0, 22'h3FFFFF, 16'hFFFF, 0, 0, 0, 0));
    send_split(mk(32768, 1, 1, 0, 0, 0, 0));
    send_split(mk(17'h1FFFF, 22'h3FFFFF, 16'hFFFF, 0, 0, 0, 0));
    send_split(mk(65536, 22'h3FFFFF, 16'hFFFF, 0, 0, 0, 1));
    send_split(mk(17'h1FFFF, 22'h3FFFFF, 16'hFFFF, 22'h3FFFFF, 22'h3FFFFF, 24'hFFFFFF, 1));
    drain();
    write_reg(REG_UNUSED, 22'h3FFFFF);

    // ties keep the earlier beat
    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_SOFT_PT));
    send_split(mk(1, 2, 3, 4, 100, 5, 0));
    send_split(mk(9, 8, 7, 6, 100, 5, 0));
    send_split(mk(9, 8, 7, 6, 50, 5, 1));
    drain();

    // mode switched in the middle of a jet
    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_Z));
    send_split(mk(1000, 11, 40, 3, 0, 0, 0));
    send_split(mk(5000, 12, 50, 4, 0, 0, 0));
    drain();
    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_MIN_ZD2));
    send_split(mk(1, 13, 1, 5, 0, 0, 0));
    send_split(mk(0, 14, 0, 6, 0, 0, 1));
    drain();

    // late kt: nothing above the cut, then cut at zero
    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_LATE_KT));
    write_reg(REG_KT_THRESHOLD, 22'h3FFFFF);
    send_split(mk(100, 100, 100, 22'h3FFFFF, 0, 0, 0));
    send_split(mk(200, 200, 200, 22'h3FFFFF, 0, 0, 1));
    drain();
    write_reg(REG_KT_THRESHOLD, 0);
    send_split(mk(300, 1, 5, 0, 0, 0, 0));
    send_split(mk(301, 2, 100, 1, 0, 0, 0));
    send_split(mk(302, 3, 100, 1, 0, 0, 0));
    send_split(mk(303, 4, 0, 22'h3FFFFF, 0, 0, 1));
    drain();

    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_DYN_KAPPA));
    write_reg(REG_ANGLE_POWER, 3);
    send_split(mk(32768, 22'h3FFFFF, 16'hFFFF, 0, 0, 0, 0));
    send_split(mk(16384, 22'h3FFFFF, 16'hFFFF, 0, 0, 0, 1));
    drain();
    write_reg(REG_ANGLE_POWER, 0);
    send_split(mk(40000, 22'h3FFFFF, 16'hFFFF, 0, 0, 0, 1));
    drain();

    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_KAPPA));
    send_split(mk(1, 1, 1, 1, 1, 24'hFFFFFF, 0));
    send_split(mk(2, 2, 2, 2, 2, 24'hFFFFFE, 1));
    drain();
    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_MAX_ZD2));
    send_split(mk(17'h1FFFF, 7, 16'hFFFF, 7, 7, 7, 1));
    drain();
    write_reg(REG_SELECT_MODE, CFG_DATA_W'(MODE_KT));
    send_split(mk(5, 5, 5, 5, 5, 5, 0));
    send_split(mk(6, 6, 6, 22'h3FFFFF, 6, 6, 1));

    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      drain();
      if (phase < 8) mode = MODE_W'(phase);
      else if (phase == 8) mode = MODE_DYN_KAPPA;
      else mode = MODE_W'($urandom_range(7));
      case ($urandom_range(3))
        0: cut = 0;
        1: cut = 22'h3FFFFF;
        2: cut = KT_W'($urandom_range(63));
        default: cut = KT_W'($urandom);
      endcase
      write_reg(REG_SELECT_MODE, CFG_DATA_W'(mode));
      write_reg(REG_ANGLE_POWER, CFG_DATA_W'((phase == 8) ? 3 : $urandom_range(3)));
      write_reg(REG_KT_THRESHOLD, cut);
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 12;
        default: idle_pct = 35;
      endcase
      calm = rand_sent > RAND_ITEMS * 85 / 100;
      phase_items = $urandom_range(30, 70);
      while (phase_items > 0 && rand_sent < RAND_ITEMS) begin
        jet_len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        for (int i = 0; i < jet_len; i++) begin
          s = rand_split(i == jet_len - 1);
          prev_split = s;
          have_prev = 1;
          send_split(s);
          rand_sent++;
        end
        phase_items -= jet_len;
      end
      phase++;
    end
    in_tvalid <= 0;

    while (sb.picks_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("jet_split_selector_core regression: pass");
    end else begin
      $display("jet_split_selector_core regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/jss_pkg.sv
rtl/core/jss_front.sv
rtl/core/jss_queue.sv
rtl/core/jss_back.sv
rtl/core/jet_split_selector_core.sv
dv/tb_jet_split_selector_core.sv
